// ===== rtl/core/vrte_pkg.sv =====
// Shared types and constants for the voxel ray trace and edit block.
package vrte_pkg;

    localparam int GRID_SIZE_DEF = 32;
    localparam int MAX_STEPS_DEF = 128;
    localparam int CFG_W = 24;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PLACE_KIND = 1'b1;
    localparam logic [23:0] MAX_DISTANCE_RST = 24'd524288;
    localparam logic [7:0] PLACE_KIND_RST = 8'd1;
    localparam logic [31:0] T_NEVER = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_PLACE  = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [23:0] origin_x;
        logic signed [23:0] origin_y;
        logic signed [23:0] origin_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [4:0]         cell_x;
        logic [4:0]         cell_y;
        logic [4:0]         cell_z;
        logic [7:0]         cell_kind;
    } cmd_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] hit_x;
        logic [4:0] hit_y;
        logic [4:0] hit_z;
        logic       edited;
        logic [4:0] edit_x;
        logic [4:0] edit_y;
        logic [4:0] edit_z;
        logic [7:0] kind_read;
    } result_t;

    // Request and answer of the shared divider.
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [15:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } div_rsp_t;

endpackage

// ===== rtl/core/voxel_ray_trace_edit.sv =====
// Top level: voxel store with trace, place, remove, write and read actions.
// Write/read: access, access-wait and done states from start to done. Trace:
// clear pass-free set-up of 6 divisions on one shared divider, then check,
// read and evaluate states per DDA step, up to MAX_STEPS steps, then an edit state.
// One transaction at a time; busy stays high until done pulses.
// After reset a clearing pass, writing one store word per cycle over all words
// (GRID_SIZE^3 for a power-of-two GRID_SIZE), empties the store, busy high.
module voxel_ray_trace_edit
#(
    parameter int GRID_SIZE = vrte_pkg::GRID_SIZE_DEF,
    parameter int MAX_STEPS = vrte_pkg::MAX_STEPS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  vrte_pkg::cmd_t                  cmd,
    output logic                            done,
    output vrte_pkg::result_t               result,
    input  logic                            cfg_we,
    input  logic [vrte_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vrte_pkg::CFG_W-1:0]      cfg_data
);

    localparam int CW = $clog2(GRID_SIZE);
    localparam int AW = 3 * CW;
    localparam int DEPTH = 2 ** AW;
    localparam int SW = $clog2(MAX_STEPS + 1);
    localparam int CELLW = 10;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ACC, S_ACC_WAIT, S_SETUP, S_DIV_WAIT,
        S_CHECK, S_READ, S_EVAL, S_EDIT, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [23:0] maxd_reg;
    logic [7:0]  pkind_reg;
    vrte_pkg::cmd_t cmd_reg, cmd_next;

    logic signed [CELLW-1:0] c_reg [3], c_next [3];
    logic [31:0] td_reg [3], td_next [3];
    logic [31:0] tm_reg [3], tm_next [3];
    logic [16:0] dist_reg [3], dist_next [3];
    logic [15:0] ad_reg [3], ad_next [3];
    logic        pos_reg [3], pos_next [3];
    logic        nz_reg [3], nz_next [3];
    logic [CW-1:0] p_reg [3], p_next [3];
    logic [CW-1:0] h_reg [3], h_next [3];
    logic        prev_reg, prev_next;
    logic        hit_reg, hit_next;
    logic [2:0]  dsel_reg, dsel_next;
    logic [SW-1:0] step_reg, step_next;
    vrte_pkg::result_t res_reg, res_next;
    logic        done_reg, done_next;

    vrte_pkg::div_req_t dreq;
    vrte_pkg::div_rsp_t drsp;
    logic          m_we;
    logic [AW-1:0] m_addr;
    logic [7:0]    m_wdata, m_rdata;

    vrte_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    vrte_store #(.DEPTH(DEPTH), .AW(AW)) u_store
    (
        .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
    );

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? vrte_pkg::T_NEVER : s[31:0];
    endfunction

    function automatic logic [AW-1:0] flat_addr(input logic [CW-1:0] x,
                                                input logic [CW-1:0] y,
                                                input logic [CW-1:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [4:0] rep5(input logic [CW-1:0] v);
        logic [CW+4:0] w;
        w = {5'd0, v};
        return w[4:0];
    endfunction

    logic [4:0] ccoord [3];
    logic       cmd_in_grid;
    logic [AW-1:0] cmd_addr;
    logic       cur_in_grid;
    logic [AW-1:0] cur_addr;
    logic [CW-1:0] cur_c [3];
    logic [31:0] tmin;
    logic [1:0]  ax;
    logic        step_ok;

    always_comb
    begin
        ccoord[0] = cmd_reg.cell_x;
        ccoord[1] = cmd_reg.cell_y;
        ccoord[2] = cmd_reg.cell_z;
        cmd_in_grid = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if ({27'd0, ccoord[a]} >= GRID_SIZE)
            begin
                cmd_in_grid = 1'b0;
            end
        end
        cmd_addr = flat_addr(CW'(ccoord[0]), CW'(ccoord[1]), CW'(ccoord[2]));
        cur_in_grid = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            cur_c[a] = c_reg[a][CW-1:0];
            if (c_reg[a] < 0 || c_reg[a] >= CELLW'(GRID_SIZE))
            begin
                cur_in_grid = 1'b0;
            end
        end
        cur_addr = flat_addr(cur_c[0], cur_c[1], cur_c[2]);
        tmin = tm_reg[0];
        if (tm_reg[1] < tmin) tmin = tm_reg[1];
        if (tm_reg[2] < tmin) tmin = tm_reg[2];
        if (tm_reg[0] <= tm_reg[1] && tm_reg[0] <= tm_reg[2]) ax = 2'd0;
        else if (tm_reg[1] <= tm_reg[2]) ax = 2'd1;
        else ax = 2'd2;
        step_ok = tmin <= {8'd0, maxd_reg};
    end

    logic signed [23:0] org [3];
    logic signed [15:0] dir [3];
    logic [23:0] uo;
    logic [16:0] sdist;
    logic [15:0] sad;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cmd_next   = cmd_reg;
        prev_next  = prev_reg;
        hit_next   = hit_reg;
        dsel_next  = dsel_reg;
        step_next  = step_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            c_next[a] = c_reg[a];
            td_next[a] = td_reg[a];
            tm_next[a] = tm_reg[a];
            dist_next[a] = dist_reg[a];
            ad_next[a] = ad_reg[a];
            pos_next[a] = pos_reg[a];
            nz_next[a] = nz_reg[a];
            p_next[a] = p_reg[a];
            h_next[a] = h_reg[a];
        end
        org[0] = cmd_reg.origin_x; org[1] = cmd_reg.origin_y; org[2] = cmd_reg.origin_z;
        dir[0] = cmd_reg.dir_x;    dir[1] = cmd_reg.dir_y;    dir[2] = cmd_reg.dir_z;
        uo = '0;
        sdist = '0;
        sad = '0;
        dreq = '0;
        m_we = 1'b0;
        m_addr = cur_addr;
        m_wdata = '0;

        case (state_reg)
            S_CLEAR:
            begin
                m_we = 1'b1;
                m_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    state_next = (cmd.action == vrte_pkg::ACT_WRITE ||
                                  cmd.action == vrte_pkg::ACT_READ) ? S_ACC : S_SETUP;
                    dsel_next = '0;
                    prev_next = 1'b0;
                    hit_next = 1'b0;
                    step_next = '0;
                end
            end
            S_ACC:
            begin
                m_addr = cmd_addr;
                state_next = S_ACC_WAIT;
            end
            S_ACC_WAIT:
            begin
                m_addr = cmd_addr;
                res_next = '0;
                if (cmd_in_grid)
                begin
                    if (cmd_reg.action == vrte_pkg::ACT_READ)
                    begin
                        res_next.kind_read = m_rdata;
                    end
                    else if (m_rdata != cmd_reg.cell_kind)
                    begin
                        m_we = 1'b1;
                        m_wdata = cmd_reg.cell_kind;
                        res_next.edited = 1'b1;
                        res_next.edit_x = cmd_reg.cell_x;
                        res_next.edit_y = cmd_reg.cell_y;
                        res_next.edit_z = cmd_reg.cell_z;
                    end
                end
                state_next = S_DONE;
            end
            S_SETUP:
            begin
                // Per axis: cell, sign, face distance; then kick the divider.
                for (int a = 0; a < 3; a++)
                begin
                    uo = org[a] + 24'sh800000;
                    c_next[a] = CELLW'(signed'({2'b00, uo[23:16]})) - CELLW'(128);
                    pos_next[a] = !dir[a][15];
                    nz_next[a] = dir[a] != 0;
                    ad_next[a] = dir[a][15] ? 16'(-dir[a]) : dir[a];
                    dist_next[a] = dir[a][15] ? {1'b0, uo[15:0]}
                                              : 17'h10000 - {1'b0, uo[15:0]};
                end
                state_next = S_DIV_WAIT;
                dsel_next = '0;
                dreq.start = 1'b1;
                dreq.num = 32'h4000_0000;
                dreq.den = dir[0][15] ? 16'(-dir[0]) : dir[0];
            end
            S_DIV_WAIT:
            begin
                // Six divisions: delta then first boundary for x, y and z.
                sdist = dist_reg[dsel_reg[2:1]];
                sad = ad_reg[dsel_reg[2:1]];
                if (drsp.done)
                begin
                    if (dsel_reg[0])
                    begin
                        tm_next[dsel_reg[2:1]] = nz_reg[dsel_reg[2:1]] ? drsp.quot
                                                                       : vrte_pkg::T_NEVER;
                    end
                    else
                    begin
                        td_next[dsel_reg[2:1]] = nz_reg[dsel_reg[2:1]] ? drsp.quot
                                                                       : vrte_pkg::T_NEVER;
                    end
                    if (dsel_reg == 3'd5)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        dsel_next = dsel_reg + 3'd1;
                        dreq.start = 1'b1;
                        if (dsel_reg[0])
                        begin
                            dreq.num = 32'h4000_0000;
                            dreq.den = ad_reg[dsel_reg[2:1] + 2'd1];
                        end
                        else
                        begin
                            dreq.num = {1'b0, sdist, 14'd0};
                            dreq.den = sad;
                        end
                    end
                end
            end
            S_CHECK:
            begin
                if (step_reg == SW'(MAX_STEPS) || !step_ok || !cur_in_grid)
                begin
                    state_next = S_EDIT;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (m_rdata != 8'd0)
                begin
                    hit_next = 1'b1;
                    for (int a = 0; a < 3; a++) h_next[a] = cur_c[a];
                    state_next = S_EDIT;
                end
                else
                begin
                    prev_next = 1'b1;
                    for (int a = 0; a < 3; a++) p_next[a] = cur_c[a];
                    c_next[ax] = pos_reg[ax] ? c_reg[ax] + 1'b1 : c_reg[ax] - 1'b1;
                    tm_next[ax] = sat_add(tm_reg[ax], td_reg[ax]);
                    step_next = step_reg + 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_EDIT:
            begin
                // Remove clears the hit cell; place fills the previous one.
                res_next = '0;
                res_next.hit = hit_reg;
                if (hit_reg)
                begin
                    res_next.hit_x = rep5(h_reg[0]);
                    res_next.hit_y = rep5(h_reg[1]);
                    res_next.hit_z = rep5(h_reg[2]);
                end
                if (hit_reg && cmd_reg.action == vrte_pkg::ACT_REMOVE)
                begin
                    m_we = 1'b1;
                    m_addr = flat_addr(h_reg[0], h_reg[1], h_reg[2]);
                    res_next.edited = 1'b1;
                    res_next.edit_x = rep5(h_reg[0]);
                    res_next.edit_y = rep5(h_reg[1]);
                    res_next.edit_z = rep5(h_reg[2]);
                end
                else if (hit_reg && prev_reg && pkind_reg != 8'd0)
                begin
                    // previous cell was seen empty, so any nonzero kind changes it
                    m_we = 1'b1;
                    m_addr = flat_addr(p_reg[0], p_reg[1], p_reg[2]);
                    m_wdata = pkind_reg;
                    res_next.edited = 1'b1;
                    res_next.edit_x = rep5(p_reg[0]);
                    res_next.edit_y = rep5(p_reg[1]);
                    res_next.edit_z = rep5(p_reg[2]);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            maxd_reg  <= vrte_pkg::MAX_DISTANCE_RST;
            pkind_reg <= vrte_pkg::PLACE_KIND_RST;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            if (cfg_we && cfg_index == vrte_pkg::REG_MAX_DISTANCE)
            begin
                maxd_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == vrte_pkg::REG_PLACE_KIND)
            begin
                pkind_reg <= cfg_data[7:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        prev_reg <= prev_next;
        hit_reg  <= hit_next;
        dsel_reg <= dsel_next;
        step_reg <= step_next;
        res_reg  <= res_next;
        for (int a = 0; a < 3; a++)
        begin
            c_reg[a] <= c_next[a];
            td_reg[a] <= td_next[a];
            tm_reg[a] <= tm_next[a];
            dist_reg[a] <= dist_next[a];
            ad_reg[a] <= ad_next[a];
            pos_reg[a] <= pos_next[a];
            nz_reg[a] <= nz_next[a];
            p_reg[a] <= p_next[a];
            h_reg[a] <= h_next[a];
        end
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = res_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE)
        else $error("done outside idle");
    a_edit_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.edited |-> result.edit_x == 5'd0 && result.edit_z == 5'd0)
        else $error("edit coordinates without edit");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |-> step_reg <= SW'(MAX_STEPS))
        else $error("step count overran");
    a_read_noedit: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.kind_read != 8'd0 |-> !result.edited && !result.hit)
        else $error("read reported an edit");

endmodule

// ===== rtl/core/vrte_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module vrte_div
(
    input  logic             clk,
    input  logic             rst_n,
    input  vrte_pkg::div_req_t req,
    output vrte_pkg::div_rsp_t rsp
);

    logic [31:0] quot_reg, quot_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;
    logic [17:0] diff;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[15:0], quot_reg[31]};
        diff      = {1'b0, trial} - {2'b00, den_reg};
        if (req.start)
        begin
            quot_next = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[17])
            begin
                rem_next  = diff[16:0];
                quot_next = {quot_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ===== rtl/core/vrte_store.sv =====
// Voxel store memory: one read or write port, registered read data.
module vrte_store
#(
    parameter int DEPTH = 32768,
    parameter int AW = 15
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
